@@ sv/krt_pkg.sv @@
// Shared types, command and status codes for the keyed record table.
package krt_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int ENTRIES_W    = 6;

   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_SEARCH = 3'd1;
   localparam logic [2:0] CMD_UPDATE = 3'd2;
   localparam logic [2:0] CMD_DELETE = 3'd3;
   localparam logic [2:0] CMD_LIST   = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] key;
      logic [55:0]        name_text;
      logic [15:0]        party_size;
      logic [63:0]        time_low;
      logic [7:0]         time_high;
   } req_type;

   typedef struct packed {
      logic [2:0]             status;
      logic signed [31:0]     key_out;
      logic [55:0]            name_out;
      logic [15:0]            party_out;
      logic [63:0]            time_low_out;
      logic [7:0]             time_high_out;
      logic [ENTRIES_W-1:0]   entries;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic [55:0]        name;
      logic [15:0]        party;
      logic [63:0]        time_low;
      logic [7:0]         time_high;
   } rec_type;

endpackage

@@ sv/keyed_record_table_core.sv @@
// Keyed record table: scan sequencer around a single-port-pair record memory.
// One record is compared per cycle; a hit answers as soon as it is found, while a miss or an
// insert scans all N stored records first; list streams the N stored records in order.
// Insert on a full table and list on an empty table answer straight from idle, without a scan.
// Only one request is taken at a time: busy holds through the scan
// and, for delete, through the move of later records down, which runs behind the result.
// Reset clears the record count and control state; the receiver cannot stall.
module keyed_record_table_core #(
   parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  krt_pkg::req_type  req_data,
   output logic              rsp_valid,
   output krt_pkg::rsp_type  rsp_data
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = krt_pkg::ENTRIES_W;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT} state_type;

   state_type         state_ff, state_in;
   krt_pkg::req_type  req_ff, req_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     rd_idx_ff, rd_idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AW-1:0]     rd_at_ff, rd_at_in;
   logic              rsp_valid_ff, rsp_valid_in;
   krt_pkg::rsp_type  rsp_ff, rsp_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   krt_pkg::rec_type  wr_data;
   logic              rd_en;
   krt_pkg::rec_type  rd_data;

   logic              hit;
   logic              is_last;
   logic              scan_end;
   logic              issue;
   krt_pkg::rec_type  req_rec;
   krt_pkg::rec_type  upd_rec;

   function automatic krt_pkg::rsp_type mk_rsp(
      input logic [2:0]       status,
      input krt_pkg::rec_type rec,
      input logic [EW-1:0]    entries,
      input logic             last
   );
      krt_pkg::rsp_type r;
      r.status        = status;
      r.key_out       = rec.key;
      r.name_out      = rec.name;
      r.party_out     = rec.party;
      r.time_low_out  = rec.time_low;
      r.time_high_out = rec.time_high;
      r.entries       = entries;
      r.last          = last;
      return r;
   endfunction

   krt_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign req_rec = '{key: req_ff.key, name: req_ff.name_text, party: req_ff.party_size,
                      time_low: req_ff.time_low, time_high: req_ff.time_high};
   assign upd_rec = '{key: rd_data.key, name: rd_data.name, party: req_ff.party_size,
                      time_low: req_ff.time_low, time_high: req_ff.time_high};

   assign hit      = rd_vld_ff && (rd_data.key == req_ff.key);
   assign is_last  = (CW'(rd_at_ff) + CW'(1)) == count_ff;
   assign scan_end = !rd_vld_ff && (rd_idx_ff >= count_ff);
   assign issue    = (state_ff != S_IDLE) && (rd_idx_ff < count_ff);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      rd_vld_in    = 1'b0;
      rd_at_in     = rd_at_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = rd_at_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;

      if (issue) begin
         rd_en     = 1'b1;
         rd_idx_in = rd_idx_ff + CW'(1);
         rd_vld_in = 1'b1;
         rd_at_in  = rd_idx_ff[AW-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            rd_idx_in = '0;
            if (start) begin
               req_in = req_data;
               case (req_data.cmd) inside
                  krt_pkg::CMD_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = mk_rsp(krt_pkg::ST_FULL, '0, EW'(count_ff), 1'b1);
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  krt_pkg::CMD_SEARCH, krt_pkg::CMD_UPDATE, krt_pkg::CMD_DELETE: begin
                     state_in = S_SCAN;
                  end
                  krt_pkg::CMD_LIST: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = mk_rsp(krt_pkg::ST_EMPTY, '0, EW'(count_ff), 1'b1);
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            case (req_ff.cmd)
               krt_pkg::CMD_LIST: begin
                  if (rd_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(krt_pkg::ST_OK, rd_data, EW'(count_ff), is_last);
                     if (is_last) begin
                        state_in = S_IDLE;
                     end
                  end else if (scan_end) begin
                     state_in = S_IDLE;
                  end
               end
               krt_pkg::CMD_INSERT: begin
                  if (hit) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(krt_pkg::ST_DUPLICATE, '0, EW'(count_ff), 1'b1);
                     state_in = S_IDLE;
                  end else if (scan_end) begin
                     wr_en        = 1'b1;
                     wr_addr      = count_ff[AW-1:0];
                     wr_data      = req_rec;
                     count_in     = count_ff + CW'(1);
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(krt_pkg::ST_OK, req_rec,
                                     EW'(count_ff + CW'(1)), 1'b1);
                     state_in = S_IDLE;
                  end
               end
               krt_pkg::CMD_SEARCH: begin
                  if (hit) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(krt_pkg::ST_OK, rd_data, EW'(count_ff), 1'b1);
                     state_in = S_IDLE;
                  end else if (scan_end) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(krt_pkg::ST_NOT_FOUND, '0, EW'(count_ff), 1'b1);
                     state_in = S_IDLE;
                  end
               end
               krt_pkg::CMD_UPDATE: begin
                  if (hit) begin
                     wr_en        = 1'b1;
                     wr_addr      = rd_at_ff;
                     wr_data      = upd_rec;
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(krt_pkg::ST_OK, upd_rec, EW'(count_ff), 1'b1);
                     state_in = S_IDLE;
                  end else if (scan_end) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(krt_pkg::ST_NOT_FOUND, '0, EW'(count_ff), 1'b1);
                     state_in = S_IDLE;
                  end
               end
               krt_pkg::CMD_DELETE: begin
                  if (hit) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(krt_pkg::ST_OK, rd_data,
                                     EW'(count_ff - CW'(1)), 1'b1);
                     state_in = S_SHIFT;
                  end else if (scan_end) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(krt_pkg::ST_NOT_FOUND, '0, EW'(count_ff), 1'b1);
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SHIFT: begin
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_at_ff - AW'(1);
               wr_data = rd_data;
            end
            if (scan_end) begin
               count_in = count_ff - CW'(1);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      rd_at_ff <= rd_at_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("record count above capacity");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.cmd == krt_pkg::CMD_SEARCH ||
                          req_data.cmd == krt_pkg::CMD_UPDATE ||
                          req_data.cmd == krt_pkg::CMD_DELETE)) |=> busy)
      else $error("lookup request did not start a scan");

   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != krt_pkg::ST_OK) |-> rsp_data.last)
      else $error("reject response without last");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) <= count_ff))
      else $error("memory write beyond stored records");
`endif

endmodule

@@ sv/krt_mem.sv @@
// Record memory: one write port, one read port with registered read data.
module krt_mem #(
   parameter int DEPTH = krt_pkg::CAPACITY_DEF,
   parameter int AW    = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  krt_pkg::rec_type  wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output krt_pkg::rec_type  rd_data
);

   krt_pkg::rec_type mem_ff [DEPTH];
   krt_pkg::rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the keyed record table core: directed and random requests against a model.
`timescale 1ns / 100ps

module tb;
   import krt_pkg::*;

   localparam int TABLE_DEPTH = CAPACITY_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int KEY_POOL_N  = 40;
   localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] CMD_UNKNOWN_MID = 3'd6;
   localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;
   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   rec_type           table_rec [TABLE_DEPTH];
   int                table_count = 0;
   rsp_type           answer_queue [$];
   logic signed [31:0] key_pool [KEY_POOL_N];
   int                fail_count = 0;

   keyed_record_table_core #(
      .CAPACITY (TABLE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: FAIL");
      $finish;
   end

   function automatic int find_record(logic signed [31:0] k);
      for (int i = 0; i < table_count; i++)
         if (table_rec[i].key == k)
            return i;
      return -1;
   endfunction

   function automatic rsp_type answer(logic [2:0] st, rec_type rec, logic lst);
      rsp_type a;
      a = '0;
      a.status        = st;
      a.key_out       = rec.key;
      a.name_out      = rec.name;
      a.party_out     = rec.party;
      a.time_low_out  = rec.time_low;
      a.time_high_out = rec.time_high;
      a.entries       = table_count[ENTRIES_W-1:0];
      a.last          = lst;
      return a;
   endfunction

   task automatic model_table_op(input req_type r);
      int      idx;
      rec_type rec;
      idx = find_record(r.key);
      case (r.cmd)
         CMD_INSERT: begin
            if (table_count >= TABLE_DEPTH) begin
               answer_queue.push_back(answer(ST_FULL, '0, 1'b1));
            end else if (idx >= 0) begin
               answer_queue.push_back(answer(ST_DUPLICATE, '0, 1'b1));
            end else begin
               rec.key       = r.key;
               rec.name      = r.name_text;
               rec.party     = r.party_size;
               rec.time_low  = r.time_low;
               rec.time_high = r.time_high;
               table_rec[table_count] = rec;
               table_count++;
               answer_queue.push_back(answer(ST_OK, rec, 1'b1));
            end
         end
         CMD_SEARCH: begin
            if (idx >= 0)
               answer_queue.push_back(answer(ST_OK, table_rec[idx], 1'b1));
            else
               answer_queue.push_back(answer(ST_NOT_FOUND, '0, 1'b1));
         end
         CMD_UPDATE: begin
            if (idx >= 0) begin
               table_rec[idx].party     = r.party_size;
               table_rec[idx].time_low  = r.time_low;
               table_rec[idx].time_high = r.time_high;
               answer_queue.push_back(answer(ST_OK, table_rec[idx], 1'b1));
            end else begin
               answer_queue.push_back(answer(ST_NOT_FOUND, '0, 1'b1));
            end
         end
         CMD_DELETE: begin
            if (idx >= 0) begin
               rec = table_rec[idx];
               for (int i = idx; i + 1 < table_count; i++)
                  table_rec[i] = table_rec[i + 1];
               table_count--;
               answer_queue.push_back(answer(ST_OK, rec, 1'b1));
            end else begin
               answer_queue.push_back(answer(ST_NOT_FOUND, '0, 1'b1));
            end
         end
         CMD_LIST: begin
            if (table_count == 0)
               answer_queue.push_back(answer(ST_EMPTY, '0, 1'b1));
            else
               for (int i = 0; i < table_count; i++)
                  answer_queue.push_back(answer(ST_OK, table_rec[i], i + 1 == table_count));
         end
         default: begin
         end
      endcase
   endtask

   function automatic void report_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch: expected %h actual %h", $time, field, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (answer_queue.size() == 0) begin
            $display("%0t: unexpected result: expected none actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = answer_queue.pop_front();
            report_field("status", want.status, rsp_data.status);
            report_field("key_out", want.key_out, rsp_data.key_out);
            report_field("name_out", want.name_out, rsp_data.name_out);
            report_field("party_out", want.party_out, rsp_data.party_out);
            report_field("time_low_out", want.time_low_out, rsp_data.time_low_out);
            report_field("time_high_out", want.time_high_out, rsp_data.time_high_out);
            report_field("entries", want.entries, rsp_data.entries);
            report_field("last", want.last, rsp_data.last);
         end
      end
   end

   task automatic send_request(input req_type r);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      model_table_op(r);
   endtask

   task automatic idle_sender(input int pct);
      int n;
      n = 0;
      if ($urandom_range(0, 99) < pct)
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain_answers();
      start <= 1'b0;
      while (answer_queue.size() != 0) @(posedge clock);
   endtask

   function automatic req_type make_req(logic [2:0] c, logic signed [31:0] k, logic [55:0] n,
                                        logic [15:0] p, logic [63:0] tl, logic [7:0] th);
      req_type r;
      r.cmd        = c;
      r.key        = k;
      r.name_text  = n;
      r.party_size = p;
      r.time_low   = tl;
      r.time_high  = th;
      return r;
   endfunction

   function automatic req_type random_fields(logic [2:0] c, logic signed [31:0] k);
      return make_req(c, k, 56'({$urandom, $urandom}), 16'($urandom),
                      {$urandom, $urandom}, 8'($urandom));
   endfunction

   function automatic req_type random_request(int insert_pct);
      logic [2:0]         c;
      logic signed [31:0] k;
      int                 roll;
      if ($urandom_range(0, 99) < insert_pct) begin
         c = CMD_INSERT;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 28)      c = CMD_SEARCH;
         else if (roll < 50) c = CMD_UPDATE;
         else if (roll < 80) c = CMD_DELETE;
         else if (roll < 94) c = CMD_LIST;
         else                c = 3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
      end
      if ($urandom_range(0, 99) < 85)
         k = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
      else
         k = $urandom;
      return random_fields(c, k);
   endfunction

   function automatic logic signed [31:0] fresh_key();
      logic signed [31:0] k;
      k = $urandom;
      while (find_record(k) >= 0) k = $urandom;
      return k;
   endfunction

   task automatic test_empty_table();
      send_request(random_fields(CMD_LIST, $urandom));
      send_request(random_fields(CMD_SEARCH, KEY_MIN));
      send_request(random_fields(CMD_UPDATE, KEY_MAX));
      send_request(random_fields(CMD_DELETE, 32'sd0));
   endtask

   task automatic test_basic_ops();
      send_request(make_req(CMD_INSERT, KEY_MIN, '1, 16'hFFFF, '1, 8'hFF));
      send_request(make_req(CMD_INSERT, KEY_MAX, '0, 16'h0000, '0, 8'h00));
      send_request(random_fields(CMD_INSERT, KEY_MIN));
      send_request(random_fields(CMD_INSERT, 32'sd0));
      send_request(random_fields(CMD_SEARCH, KEY_MAX));
      send_request(random_fields(CMD_SEARCH, 32'sd1));
      send_request(make_req(CMD_UPDATE, 32'sd0, '0, 16'hFFFF, '1, 8'hFF));
      send_request(random_fields(CMD_UPDATE, -32'sd1));
      send_request(random_fields(CMD_LIST, $urandom));
      send_request(random_fields(CMD_DELETE, KEY_MAX));
      send_request(random_fields(CMD_DELETE, KEY_MIN));
      send_request(random_fields(CMD_LIST, $urandom));
      send_request(random_fields(CMD_DELETE, 32'sd0));
   endtask

   task automatic test_unknown_cmds();
      send_request(random_fields(CMD_INSERT, 32'sd77));
      send_request(random_fields(CMD_UNKNOWN_LO, 32'sd77));
      send_request(random_fields(CMD_UNKNOWN_MID, 32'sd77));
      send_request(random_fields(CMD_UNKNOWN_HI, 32'sd5));
      send_request(random_fields(CMD_LIST, 32'sd77));
      send_request(random_fields(CMD_DELETE, 32'sd77));
   endtask

   task automatic test_full_table();
      while (table_count < TABLE_DEPTH) begin
         idle_sender(23);
         send_request(random_fields(CMD_INSERT, fresh_key()));
      end
      send_request(random_fields(CMD_INSERT, fresh_key()));
      send_request(random_fields(CMD_INSERT, table_rec[0].key));
      send_request(random_fields(CMD_LIST, $urandom));
      send_request(random_fields(CMD_DELETE, table_rec[TABLE_DEPTH - 1].key));
      send_request(random_fields(CMD_INSERT, fresh_key()));
      send_request(random_fields(CMD_DELETE, table_rec[0].key));
      send_request(random_fields(CMD_SEARCH, table_rec[5].key));
      send_request(random_fields(CMD_UPDATE, table_rec[10].key));
      send_request(random_fields(CMD_LIST, $urandom));
   endtask

   task automatic test_random(input int gap_pct, input int insert_pct, input int count);
      for (int n = 0; n < count; n++) begin
         idle_sender(gap_pct);
         send_request(random_request(insert_pct));
         if (n == count / 2)
            drain_answers();
      end
      drain_answers();
   endtask

   initial begin
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = 32'sd0;
      key_pool[3] = -32'sd1;
      for (int i = 4; i < KEY_POOL_N; i++)
         key_pool[i] = $urandom;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_basic_ops();
      test_unknown_cmds();
      drain_answers();
      test_full_table();
      test_random(0, 45, 62);
      test_random(51, 30, 62);
      test_random(23, 40, 62);
      test_random(0, 20, 62);
      start <= 1'b0;
      while (answer_queue.size() != 0) @(posedge clock);
      repeat (3 * TABLE_DEPTH + 10) @(posedge clock);
      if (fail_count == 0 && answer_queue.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
